FILE: rtl/core/pas_pkg.sv
`timescale 1ns / 1ps

package pas_pkg;

    // Threshold register: unsigned Q1.16, one integer bit
    localparam int THR_W = 17;
    localparam logic [THR_W-1:0] THR_RESET = 17'd65411;

    // Fraction bits of the threshold; the squared dot product is scaled by this
    localparam int FRAC_W = 16;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIRST,
        ST_PREP,
        ST_CHECK,
        ST_GO,
        ST_WAIT,
        ST_CMP,
        ST_KEEP,
        ST_TAIL,
        ST_LAST
    } state_t;

    // Products run on the shared multiplier, in this order
    typedef enum logic [3:0] {
        OP_AX2,   // ax*ax, clears the accumulator
        OP_AY2,   // + ay*ay -> la
        OP_BX2,   // bx*bx, clears the accumulator
        OP_BY2,   // + by*by -> lb
        OP_P1,    // +/- ax*bx, clears the accumulator
        OP_P2,    // +/- ay*by -> dot
        OP_DSQ,   // dot*dot
        OP_LALB,  // la*lb
        OP_RTH    // (la*lb)*threshold
    } op_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;      // latch the incoming point
        logic prep;         // register segment magnitudes and signs
        logic start;        // launch the product selected by op
        logic store;        // write the finished product to its destination
        logic set_anchor_pt;
        logic set_anchor_held;
        logic set_held;
        logic push;         // load the output register
        logic push_held;    // output the held point, else the current point
        logic push_done;
        op_t  op;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic a_zero;       // held point equals anchor
        logic b_zero;       // next point equals held point
        logic mul_busy;
        logic keep;         // turn is sharp enough to keep the held point
        logic can_push;     // output register free this cycle
    } status_t;

endpackage

FILE: rtl/core/polyline_angle_simplify.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake          Payload
// s_axis   in   tvalid / tready    tdata {point_y, point_x}, tlast end_of_curve
// m_axis   out  tvalid / tready    tdata {kept_point_y, kept_point_x}, tlast curve_done
// cfg      in   valid / ready      cos_sq_threshold (17 bits)
//
// One point is processed at a time. A first point or a point with no held predecessor
// runs no products.
// Judging a held interior point runs nine products in turn on one shared multiplier
// that retires one (COORD_WIDTH+1)-bit digit per cycle and finishes a product early
// when its multiplier has zero upper digits. A waiting result
// blocks only the load of a further result. Reset is asynchronous, active low.

module polyline_angle_simplify #(
    parameter int COORD_WIDTH = 16
) (
    input  logic clk,
    input  logic rst_n,

    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [COORD_WIDTH-1:0] point_x, [2*COORD_WIDTH-1:COORD_WIDTH] point_y
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
    input  logic                                   s_axis_tlast,

    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // [COORD_WIDTH-1:0] kept_point_x, [2*COORD_WIDTH-1:COORD_WIDTH] kept_point_y
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0]     m_axis_tdata,
    output logic                                   m_axis_tlast,

    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [pas_pkg::THR_W-1:0]              cfg_data
);

    localparam int TDATA_W = ((2 * COORD_WIDTH + 7) / 8) * 8;

    pas_pkg::cmd_t         cmd;
    pas_pkg::status_t      status;
    logic [COORD_WIDTH-1:0] out_x, out_y;

    assign cfg_ready = 1'b1;

    pas_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_last  (s_axis_tlast),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pas_datapath #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_x      (s_axis_tdata[COORD_WIDTH-1:0]),
        .in_y      (s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_thr   (cfg_data),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_done  (m_axis_tlast)
    );

    // Pack the kept point, zero padding to whole bytes
    assign m_axis_tdata = TDATA_W'({out_y, out_x});

endmodule

FILE: rtl/core/pas_mul.sv
`timescale 1ns / 1ps

// Shared multiply-accumulate unit: one DW-bit digit of b per cycle
module pas_mul #(
    parameter int PW = 85,
    parameter int AW = 34,
    parameter int BW = 68,
    parameter int DW = 17
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          clr,
    input  logic          neg,
    input  logic [AW-1:0] a,
    input  logic [BW-1:0] b,
    output logic [PW-1:0] acc,
    output logic          busy
);

    localparam int ND = (BW + DW - 1) / DW;
    localparam int IW = (ND > 1) ? $clog2(ND) : 1;

    logic [BW-1:0]    b_reg;
    logic [BW-1:0]    b_next;
    logic [AW-1:0]    a_reg;
    logic [IW-1:0]    idx_reg;
    logic [PW-1:0]    acc_reg;
    logic             neg_reg;
    logic [DW-1:0]    digit;
    logic [AW+DW-1:0] pp;
    logic [PW-1:0]    shifted;
    logic [PW-1:0]    term;

    // Form the partial product of the current digit and align it
    assign digit   = b_reg[DW-1:0];
    assign pp      = (AW+DW)'(a_reg) * (AW+DW)'(digit);
    assign shifted = PW'(pp) << (DW * idx_reg);
    assign term    = neg_reg ? (~shifted + 1'b1) : shifted;
    assign busy    = |b_reg;
    assign acc     = acc_reg;

    // Load a new multiplier, or retire one digit
    always_comb
    begin
        b_next = b_reg;
        if (start)
        begin
            b_next = b;
        end
        else if (busy)
        begin
            b_next = b_reg >> DW;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_reg <= '0;
        end
        else
        begin
            b_reg <= b_next;
        end
    end

    // Advance the digit position and accumulate
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            idx_reg <= '0;
            neg_reg <= neg;
            if (clr)
            begin
                acc_reg <= '0;
            end
        end
        else if (busy)
        begin
            acc_reg <= acc_reg + term;
            idx_reg <= idx_reg + 1'b1;
        end
    end

endmodule

FILE: rtl/core/pas_datapath.sv
`timescale 1ns / 1ps

module pas_datapath #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pas_pkg::cmd_t          cmd,
    output pas_pkg::status_t       status,
    input  logic [COORD_WIDTH-1:0] in_x,
    input  logic [COORD_WIDTH-1:0] in_y,
    input  logic                   cfg_we,
    input  logic [pas_pkg::THR_W-1:0] cfg_thr,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [COORD_WIDTH-1:0] out_x,
    output logic [COORD_WIDTH-1:0] out_y,
    output logic                   out_done
);

    localparam int W      = COORD_WIDTH;
    localparam int MAG_W  = W + 1;
    localparam int LEN_W  = 2 * W + 2;
    localparam int DOT_W  = 2 * W + 2;
    localparam int DSQ_W  = 4 * W + 4;
    localparam int R_W    = 4 * W + 4;
    localparam int PW     = R_W + pas_pkg::THR_W;
    localparam int AW     = LEN_W;
    localparam int BW     = R_W;
    localparam int DW     = MAG_W;

    logic [W-1:0] pt_x_reg, pt_y_reg;
    logic [W-1:0] anchor_x_reg, anchor_y_reg;
    logic [W-1:0] held_x_reg, held_y_reg;
    logic [pas_pkg::THR_W-1:0] thr_reg;

    logic [MAG_W-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic             sx_reg, sy_reg;
    logic [LEN_W-1:0] la_reg, lb_reg;
    logic [DOT_W-1:0] dot_reg;
    logic [DSQ_W-1:0] dsq_reg;
    logic [R_W-1:0]   r_reg;
    logic [PW-1:0]    rth_reg;

    logic             out_valid_reg, out_valid_next;
    logic [W-1:0]     out_x_reg, out_y_reg;
    logic             out_done_reg;

    logic signed [W:0] dax, day, dbx, dby;
    logic [MAG_W-1:0]  max, may, mbx, mby;

    logic [AW-1:0]    mul_a;
    logic [BW-1:0]    mul_b;
    logic             mul_clr, mul_neg;
    logic [PW-1:0]    mul_acc;
    logic             mul_busy;
    logic [DOT_W:0]   dot_s;
    logic [DOT_W-1:0] dot_mag;
    logic [PW-1:0]    dsq_scaled;

    // Segment vectors a = held - anchor and b = point - held
    always_comb
    begin
        dax = $signed({held_x_reg[W-1], held_x_reg}) - $signed({anchor_x_reg[W-1], anchor_x_reg});
        day = $signed({held_y_reg[W-1], held_y_reg}) - $signed({anchor_y_reg[W-1], anchor_y_reg});
        dbx = $signed({pt_x_reg[W-1], pt_x_reg}) - $signed({held_x_reg[W-1], held_x_reg});
        dby = $signed({pt_y_reg[W-1], pt_y_reg}) - $signed({held_y_reg[W-1], held_y_reg});
        max = dax[W] ? (~dax + 1'b1) : dax;
        may = day[W] ? (~day + 1'b1) : day;
        mbx = dbx[W] ? (~dbx + 1'b1) : dbx;
        mby = dby[W] ? (~dby + 1'b1) : dby;
    end

    // Select operands for the product in flight; the wide operand goes to b
    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        mul_clr = 1'b0;
        mul_neg = 1'b0;
        case (cmd.op)
            pas_pkg::OP_AX2:
            begin
                mul_a   = AW'(ax_reg);
                mul_b   = BW'(ax_reg);
                mul_clr = 1'b1;
            end
            pas_pkg::OP_AY2:
            begin
                mul_a = AW'(ay_reg);
                mul_b = BW'(ay_reg);
            end
            pas_pkg::OP_BX2:
            begin
                mul_a   = AW'(bx_reg);
                mul_b   = BW'(bx_reg);
                mul_clr = 1'b1;
            end
            pas_pkg::OP_BY2:
            begin
                mul_a = AW'(by_reg);
                mul_b = BW'(by_reg);
            end
            pas_pkg::OP_P1:
            begin
                mul_a   = AW'(ax_reg);
                mul_b   = BW'(bx_reg);
                mul_clr = 1'b1;
                mul_neg = sx_reg;
            end
            pas_pkg::OP_P2:
            begin
                mul_a   = AW'(ay_reg);
                mul_b   = BW'(by_reg);
                mul_neg = sy_reg;
            end
            pas_pkg::OP_DSQ:
            begin
                mul_a   = AW'(dot_reg);
                mul_b   = BW'(dot_reg);
                mul_clr = 1'b1;
            end
            pas_pkg::OP_LALB:
            begin
                mul_a   = AW'(la_reg);
                mul_b   = BW'(lb_reg);
                mul_clr = 1'b1;
            end
            pas_pkg::OP_RTH:
            begin
                mul_a   = AW'(thr_reg);
                mul_b   = BW'(r_reg);
                mul_clr = 1'b1;
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    pas_mul #(
        .PW (PW),
        .AW (AW),
        .BW (BW),
        .DW (DW)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.start),
        .clr   (mul_clr),
        .neg   (mul_neg),
        .a     (mul_a),
        .b     (mul_b),
        .acc   (mul_acc),
        .busy  (mul_busy)
    );

    // Magnitude of the signed dot product
    assign dot_s   = mul_acc[DOT_W:0];
    assign dot_mag = dot_s[DOT_W] ? DOT_W'(~dot_s + 1'b1) : dot_s[DOT_W-1:0];

    // Keep when dot^2 * 2^16 < la * lb * threshold
    assign dsq_scaled = PW'({dsq_reg, {pas_pkg::FRAC_W{1'b0}}});

    assign status.a_zero   = (ax_reg == '0) && (ay_reg == '0);
    assign status.b_zero   = (bx_reg == '0) && (by_reg == '0);
    assign status.mul_busy = mul_busy;
    assign status.keep     = dsq_scaled < rth_reg;
    assign status.can_push = !out_valid_reg || out_ready;

    // Anchor, held point and threshold storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anchor_x_reg <= '0;
            anchor_y_reg <= '0;
            held_x_reg   <= '0;
            held_y_reg   <= '0;
            thr_reg      <= pas_pkg::THR_RESET;
        end
        else
        begin
            if (cmd.set_anchor_pt)
            begin
                anchor_x_reg <= pt_x_reg;
                anchor_y_reg <= pt_y_reg;
            end
            else if (cmd.set_anchor_held)
            begin
                anchor_x_reg <= held_x_reg;
                anchor_y_reg <= held_y_reg;
            end
            if (cmd.set_held)
            begin
                held_x_reg <= pt_x_reg;
                held_y_reg <= pt_y_reg;
            end
            if (cfg_we)
            begin
                thr_reg <= cfg_thr;
            end
        end
    end

    // Capture the point, latch intermediate results and load the output register
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pt_x_reg <= in_x;
            pt_y_reg <= in_y;
        end
        if (cmd.prep)
        begin
            ax_reg <= max;
            ay_reg <= may;
            bx_reg <= mbx;
            by_reg <= mby;
            sx_reg <= dax[W] ^ dbx[W];
            sy_reg <= day[W] ^ dby[W];
        end
        if (cmd.store)
        begin
            case (cmd.op)
                pas_pkg::OP_AY2:  la_reg  <= mul_acc[LEN_W-1:0];
                pas_pkg::OP_BY2:  lb_reg  <= mul_acc[LEN_W-1:0];
                pas_pkg::OP_P2:   dot_reg <= dot_mag;
                pas_pkg::OP_DSQ:  dsq_reg <= mul_acc[DSQ_W-1:0];
                pas_pkg::OP_LALB: r_reg   <= mul_acc[R_W-1:0];
                pas_pkg::OP_RTH:  rth_reg <= mul_acc;
                default:          ;
            endcase
        end
        if (cmd.push)
        begin
            out_x_reg    <= cmd.push_held ? held_x_reg : pt_x_reg;
            out_y_reg    <= cmd.push_held ? held_y_reg : pt_y_reg;
            out_done_reg <= cmd.push_done;
        end
    end

    // Output register: fill on push, drain on request
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.push)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_done  = out_done_reg;

endmodule

FILE: rtl/core/pas_ctrl.sv
`timescale 1ns / 1ps

module pas_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_last,
    output logic             in_ready,
    input  pas_pkg::status_t status,
    output pas_pkg::cmd_t    cmd
);

    pas_pkg::state_t state_reg, state_next;
    pas_pkg::op_t    op_reg, op_next;
    logic            awaiting_reg, awaiting_next;
    logic            held_valid_reg, held_valid_next;
    logic            last_reg, last_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pas_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (awaiting_reg)
                    begin
                        state_next = pas_pkg::ST_FIRST;
                    end
                    else if (held_valid_reg)
                    begin
                        state_next = pas_pkg::ST_PREP;
                    end
                    else
                    begin
                        state_next = pas_pkg::ST_TAIL;
                    end
                end
            end
            pas_pkg::ST_FIRST:
            begin
                if (status.can_push)
                begin
                    state_next = last_reg ? pas_pkg::ST_LAST : pas_pkg::ST_IDLE;
                end
            end
            pas_pkg::ST_PREP:
            begin
                state_next = pas_pkg::ST_CHECK;
            end
            pas_pkg::ST_CHECK:
            begin
                if (status.a_zero || status.b_zero)
                begin
                    state_next = pas_pkg::ST_TAIL;
                end
                else
                begin
                    state_next = pas_pkg::ST_GO;
                end
            end
            pas_pkg::ST_GO:
            begin
                state_next = pas_pkg::ST_WAIT;
            end
            pas_pkg::ST_WAIT:
            begin
                if (!status.mul_busy)
                begin
                    state_next = (op_reg == pas_pkg::OP_RTH) ? pas_pkg::ST_CMP
                                                              : pas_pkg::ST_GO;
                end
            end
            pas_pkg::ST_CMP:
            begin
                state_next = status.keep ? pas_pkg::ST_KEEP : pas_pkg::ST_TAIL;
            end
            pas_pkg::ST_KEEP:
            begin
                if (status.can_push)
                begin
                    state_next = pas_pkg::ST_TAIL;
                end
            end
            pas_pkg::ST_TAIL:
            begin
                state_next = last_reg ? pas_pkg::ST_LAST : pas_pkg::ST_IDLE;
            end
            pas_pkg::ST_LAST:
            begin
                if (status.can_push)
                begin
                    state_next = pas_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pas_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands and flag updates
    always_comb
    begin
        in_ready        = 1'b0;
        cmd             = '0;
        cmd.op          = op_reg;
        op_next         = op_reg;
        awaiting_next   = awaiting_reg;
        held_valid_next = held_valid_reg;
        last_next       = last_reg;
        unique case (state_reg)
            pas_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    last_next   = in_last;
                end
            end
            pas_pkg::ST_FIRST:
            begin
                if (status.can_push)
                begin
                    cmd.push = 1'b1;
                    if (!last_reg)
                    begin
                        cmd.set_anchor_pt = 1'b1;
                        awaiting_next     = 1'b0;
                        held_valid_next   = 1'b0;
                    end
                end
            end
            pas_pkg::ST_PREP:
            begin
                cmd.prep = 1'b1;
            end
            pas_pkg::ST_CHECK:
            begin
                op_next = pas_pkg::OP_AX2;
            end
            pas_pkg::ST_GO:
            begin
                cmd.start = 1'b1;
            end
            pas_pkg::ST_WAIT:
            begin
                if (!status.mul_busy)
                begin
                    cmd.store = 1'b1;
                    if (op_reg != pas_pkg::OP_RTH)
                    begin
                        op_next = pas_pkg::op_t'(op_reg + 4'd1);
                    end
                end
            end
            pas_pkg::ST_CMP:
            begin
                cmd.op = op_reg;
            end
            pas_pkg::ST_KEEP:
            begin
                if (status.can_push)
                begin
                    cmd.push            = 1'b1;
                    cmd.push_held       = 1'b1;
                    cmd.set_anchor_held = 1'b1;
                end
            end
            pas_pkg::ST_TAIL:
            begin
                if (!last_reg)
                begin
                    cmd.set_held    = 1'b1;
                    held_valid_next = 1'b1;
                end
            end
            pas_pkg::ST_LAST:
            begin
                if (status.can_push)
                begin
                    cmd.push        = 1'b1;
                    cmd.push_done   = 1'b1;
                    awaiting_next   = 1'b1;
                    held_valid_next = 1'b0;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Hold controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pas_pkg::ST_IDLE;
            op_reg         <= pas_pkg::OP_AX2;
            awaiting_reg   <= 1'b1;
            held_valid_reg <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            awaiting_reg   <= awaiting_next;
            held_valid_reg <= held_valid_next;
            last_reg       <= last_next;
        end
    end

endmodule

FILE: rtl/core/pas_checker.sv
`timescale 1ns / 1ps

module pas_checker #(
    parameter int COORD_WIDTH = 16
) (
    input logic clk,
    input logic rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [((2*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    input logic m_axis_tlast,
    input logic cfg_valid,
    input logic cfg_ready
);

    // Hold a stalled result steady
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output changed");

    // One point at a time: ready drops right after a request is taken
    a_in_single: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted on consecutive cycles");

    // Curve ends never leave on two consecutive cycles
    a_done_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=>
            !(m_axis_tvalid && m_axis_tready && m_axis_tlast))
        else $error("two curve ends back to back");

    // A result never rises in the cycle right after an accept
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
        else $error("result raised in the cycle after accept");

    // Configuration is always taken
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind polyline_angle_simplify pas_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_pas_checker (.*);
